// ===== sv/ciir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ciir_pkg
// Shared types, constants and microcode for the cascaded highpass filter.
// ----------------------------------------------------------------------------
package ciir_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int COEF_WIDTH    = 25;
  localparam int DELAY_WIDTH   = 40;
  localparam int PROD_WIDTH    = 46;
  localparam int PART_WIDTH    = 47;
  localparam int TERM_WIDTH    = 45;
  localparam int SUM_WIDTH     = 48;
  localparam int NUM_REGS      = 8;
  localparam int INDEX_WIDTH   = 4;
  localparam int PC_WIDTH      = 5;

  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [DELAY_WIDTH-1:0]  delay_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [SUM_WIDTH-1:0]    sum_t;

  // register indexes
  localparam logic [2:0] C_FIRST_B0  = 3'd0;
  localparam logic [2:0] C_FIRST_B1  = 3'd1;
  localparam logic [2:0] C_FIRST_A1  = 3'd2;
  localparam logic [2:0] C_SECOND_B0 = 3'd3;
  localparam logic [2:0] C_SECOND_B1 = 3'd4;
  localparam logic [2:0] C_SECOND_B2 = 3'd5;
  localparam logic [2:0] C_SECOND_A1 = 3'd6;
  localparam logic [2:0] C_SECOND_A2 = 3'd7;

  localparam coef_t COEF_RESET [NUM_REGS] = '{
    25'sd3584021, -25'sd3584021, -25'sd3582274,
    25'sd4194304, -25'sd8388608, 25'sd4194304, -25'sd8295075, 25'sd4102029
  };

  // multiplier operand sources
  localparam logic [1:0] SRC_FD = 2'd0;
  localparam logic [1:0] SRC_S1 = 2'd1;
  localparam logic [1:0] SRC_S2 = 2'd2;
  localparam logic [1:0] SRC_WV = 2'd3;

  // partial product operations
  localparam logic [1:0] PART_NOP  = 2'd0;
  localparam logic [1:0] PART_LO   = 2'd1;
  localparam logic [1:0] PART_TERM = 2'd2;

  // accumulator operations
  localparam logic [2:0] SUM_NOP     = 3'd0;
  localparam logic [2:0] SUM_ADD     = 3'd1;
  localparam logic [2:0] SUM_SUB     = 3'd2;
  localparam logic [2:0] SUM_SAT_SUB = 3'd3;
  localparam logic [2:0] SUM_CLR_ADD = 3'd4;

  // register load strobes {wv, fd, sd, out}
  localparam logic [3:0] LD_NONE = 4'b0000;
  localparam logic [3:0] LD_WV   = 4'b1000;
  localparam logic [3:0] LD_FD   = 4'b0100;
  localparam logic [3:0] LD_SD   = 4'b0010;
  localparam logic [3:0] LD_OUT  = 4'b0001;

  // sequencer operations
  localparam logic SEQ_NEXT = 1'b0;
  localparam logic SEQ_END  = 1'b1;

  localparam logic [PC_WIDTH-1:0] LAST_STEP = 5'd22;

  typedef struct packed {
    logic [2:0] mul_coef;
    logic [1:0] mul_src;
    logic       mul_hi;
    logic [1:0] part_op;
    logic [2:0] sum_op;
    logic       wv_load;
    logic       fd_load;
    logic       sd_load;
    logic       out_load;
    logic       seq_op;
  } ctrl_t;

  localparam logic LO = 1'b0;
  localparam logic HI = 1'b1;

  function automatic ctrl_t cw(input logic [2:0] c, input logic [1:0] s, input logic h,
                               input logic [1:0] p, input logic [2:0] so,
                               input logic [3:0] ld, input logic q);
    ctrl_t w;
    w.mul_coef = c;
    w.mul_src  = s;
    w.mul_hi   = h;
    w.part_op  = p;
    w.sum_op   = so;
    w.wv_load  = ld[3];
    w.fd_load  = ld[2];
    w.sd_load  = ld[1];
    w.out_load = ld[0];
    w.seq_op   = q;
    return w;
  endfunction

  localparam ctrl_t NOP_WORD = '0;

  // product terms take two multiplies: low 20 bits of the operand, then the high part
  function automatic ctrl_t ucode(input logic [PC_WIDTH-1:0] pc);
    ctrl_t w;
    w = NOP_WORD;
    unique case (pc)
      5'd0:  w = cw(C_FIRST_A1,  SRC_FD, LO, PART_NOP,  SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd1:  w = cw(C_FIRST_A1,  SRC_FD, HI, PART_LO,   SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd2:  w = cw(C_FIRST_B1,  SRC_FD, LO, PART_TERM, SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd3:  w = cw(C_FIRST_B1,  SRC_FD, HI, PART_LO,   SUM_SUB,     LD_NONE, SEQ_NEXT);
      5'd4:  w = cw(C_FIRST_B0,  SRC_FD, LO, PART_TERM, SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd5:  w = cw(C_FIRST_B0,  SRC_FD, LO, PART_NOP,  SUM_CLR_ADD, LD_WV,   SEQ_NEXT);
      5'd6:  w = cw(C_FIRST_B0,  SRC_WV, LO, PART_NOP,  SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd7:  w = cw(C_FIRST_B0,  SRC_WV, HI, PART_LO,   SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd8:  w = cw(C_SECOND_A1, SRC_S1, LO, PART_TERM, SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd9:  w = cw(C_SECOND_A1, SRC_S1, HI, PART_LO,   SUM_ADD,     LD_NONE, SEQ_NEXT);
      5'd10: w = cw(C_SECOND_A2, SRC_S2, LO, PART_TERM, SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd11: w = cw(C_SECOND_A2, SRC_S2, HI, PART_LO,   SUM_SAT_SUB, LD_FD,   SEQ_NEXT);
      5'd12: w = cw(C_SECOND_B1, SRC_S1, LO, PART_TERM, SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd13: w = cw(C_SECOND_B1, SRC_S1, HI, PART_LO,   SUM_SUB,     LD_NONE, SEQ_NEXT);
      5'd14: w = cw(C_SECOND_B2, SRC_S2, LO, PART_TERM, SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd15: w = cw(C_SECOND_B2, SRC_S2, HI, PART_LO,   SUM_CLR_ADD, LD_WV,   SEQ_NEXT);
      5'd16: w = cw(C_SECOND_B0, SRC_WV, LO, PART_TERM, SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd17: w = cw(C_SECOND_B0, SRC_WV, LO, PART_NOP,  SUM_ADD,     LD_NONE, SEQ_NEXT);
      5'd18: w = cw(C_SECOND_B0, SRC_WV, LO, PART_NOP,  SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd19: w = cw(C_SECOND_B0, SRC_WV, HI, PART_LO,   SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd20: w = cw(C_SECOND_B0, SRC_WV, LO, PART_TERM, SUM_NOP,     LD_NONE, SEQ_NEXT);
      5'd21: w = cw(C_SECOND_B0, SRC_WV, LO, PART_NOP,  SUM_ADD,     LD_SD,   SEQ_NEXT);
      5'd22: w = cw(C_SECOND_B0, SRC_WV, LO, PART_NOP,  SUM_NOP,     LD_OUT,  SEQ_END);
      default: w = cw(C_FIRST_B0, SRC_FD, LO, PART_NOP, SUM_NOP,     LD_NONE, SEQ_END);
    endcase
    return w;
  endfunction

  // clamp to the signed 40-bit delay range
  function automatic delay_t sat_delay(input sum_t v);
    delay_t r;
    if (v[SUM_WIDTH-1:DELAY_WIDTH-1] == '0 || v[SUM_WIDTH-1:DELAY_WIDTH-1] == '1) begin
      r = v[DELAY_WIDTH-1:0];
    end else begin
      r = {v[SUM_WIDTH-1], {(DELAY_WIDTH-1){~v[SUM_WIDTH-1]}}};
    end
    return r;
  endfunction

endpackage

// ===== sv/ciir_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ciir_seq
// Step counter and microcode ROM driving the filter datapath.
// ----------------------------------------------------------------------------
module ciir_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           out_free,
  output logic           busy,
  output ciir_pkg::ctrl_t ctrl
);
  import ciir_pkg::*;

  logic [PC_WIDTH-1:0] pc;
  ctrl_t               word;

  assign word = ucode(pc);
  assign ctrl = busy ? word : NOP_WORD;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= '0;
    end else if (busy) begin
      if (word.seq_op == SEQ_NEXT) begin
        pc <= pc + 5'd1;
      end else if (out_free) begin
        busy <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_start: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && pc == '0)
    else $error("sequencer did not restart at step zero");
  a_step: assert property (@(posedge clk) disable iff (rst)
    busy && word.seq_op == SEQ_NEXT && !start |=> pc == $past(pc) + 5'd1)
    else $error("step counter skipped");
  a_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc <= LAST_STEP)
    else $error("step counter ran past the program");
`endif

endmodule

// ===== sv/cascaded_iir_highpass_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_iir_highpass_unit
// Third-order highpass: first-order section cascaded with a biquad, both
// direct form II with 40-bit saturating delays and Q2.22 coefficients.
// ----------------------------------------------------------------------------
// usage:
//   input channel  in_valid / in_stall / sample_in, one request per sample
//   output channel out_valid / out_stall / sample_out, one request per input
//   config channel cfg_valid / cfg_ready / cfg_index / cfg_data, always ready;
//   indexes 0..7 select first_b0, first_b1, first_a1, second_b0, second_b1,
//   second_b2, second_a1, second_a2; other indexes are dropped
// a 23-step microcode program runs the eight coefficient products through one
// shared 25x21 multiplier, two multiplies per product; the result lands in
// the output register at the last step of the program
// in_stall is high while the program runs; a stalled output holds the
// program at its last step until the output register frees up
// reset clears the delays, restores the default coefficients and drops
// any pending output
// ----------------------------------------------------------------------------
module cascaded_iir_highpass_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ciir_pkg::SAMPLE_WIDTH-1:0] sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ciir_pkg::SAMPLE_WIDTH-1:0] sample_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ciir_pkg::INDEX_WIDTH-1:0]     cfg_index,
  input  logic signed [ciir_pkg::COEF_WIDTH-1:0] cfg_data
);
  import ciir_pkg::*;

  coef_t  coef [NUM_REGS];
  delay_t fd;
  delay_t s1;
  delay_t s2;
  delay_t wv;
  sum_t   sum;
  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [PART_WIDTH-1:0] part;
  logic signed [TERM_WIDTH-1:0] term;

  logic   start;
  logic   busy;
  logic   out_free;
  ctrl_t  ctrl;
  delay_t opnd;
  logic signed [20:0] opnd_part;
  logic signed [66:0] tsum;
  sum_t   term_ext;
  delay_t y40;
  logic signed [40:0] yr;
  logic signed [32:0] rq;
  sample_t res;

  assign cfg_ready = 1'b1;
  assign start     = in_valid && !busy;
  assign in_stall  = busy;
  assign out_free  = !out_valid || !out_stall;

  ciir_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef[i] <= COEF_RESET[i];
      end
    end else if (cfg_valid && cfg_ready && cfg_index < INDEX_WIDTH'(NUM_REGS)) begin
      coef[cfg_index[2:0]] <= cfg_data;
    end
  end

  // operand select and split
  always_comb begin
    case (ctrl.mul_src)
      SRC_FD:  opnd = fd;
      SRC_S1:  opnd = s1;
      SRC_S2:  opnd = s2;
      default: opnd = wv;
    endcase
    opnd_part = ctrl.mul_hi ? $signed({opnd[DELAY_WIDTH-1], opnd[DELAY_WIDTH-1:20]})
                            : $signed({1'b0, opnd[19:0]});
  end

  assign tsum     = (67'(prod) <<< 20) + 67'(part);
  assign term_ext = SUM_WIDTH'(term);

  // shared multiplier and rounding
  always_ff @(posedge clk) begin
    prod <= coef[ctrl.mul_coef] * opnd_part;
    case (ctrl.part_op)
      PART_LO:   part <= PART_WIDTH'(prod) + 47'sd2097152;
      PART_TERM: term <= $signed(tsum[66:22]);
      default:   ;
    endcase
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      sum <= {{(SUM_WIDTH-SAMPLE_WIDTH-8){sample_in[SAMPLE_WIDTH-1]}}, sample_in, 8'd0};
    end else begin
      case (ctrl.sum_op)
        SUM_ADD:     sum <= sum + term_ext;
        SUM_SUB:     sum <= sum - term_ext;
        SUM_SAT_SUB: sum <= SUM_WIDTH'(sat_delay(sum)) - term_ext;
        SUM_CLR_ADD: sum <= term_ext;
        default:     ;
      endcase
    end
  end

  // delay state
  always_ff @(posedge clk) begin
    if (rst) begin
      fd <= '0;
      s1 <= '0;
      s2 <= '0;
      wv <= '0;
    end else begin
      if (ctrl.wv_load) begin
        wv <= sat_delay(sum);
      end
      if (ctrl.fd_load) begin
        fd <= wv;
      end
      if (ctrl.sd_load) begin
        s2 <= s1;
        s1 <= wv;
      end
    end
  end

  // output rounding and clamp
  always_comb begin
    y40 = sat_delay(sum);
    yr  = 41'(y40) + 41'sd128;
    rq  = $signed(yr[40:8]);
    if (rq[32:SAMPLE_WIDTH-1] == '0 || rq[32:SAMPLE_WIDTH-1] == '1) begin
      res = rq[SAMPLE_WIDTH-1:0];
    end else begin
      res = {rq[32], {(SAMPLE_WIDTH-1){~rq[32]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load && out_free) begin
      sample_out <= res;
    end
  end

`ifndef SYNTH
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.out_load))
    else $error("output raised without a result step");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken but program not running");
  a_commit: assert property (@(posedge clk) disable iff (rst)
    ctrl.fd_load || ctrl.sd_load |-> busy && !ctrl.out_load)
    else $error("delay commit outside the program");
`endif

endmodule
